/* src/svf_pkg.sv */
package svf_pkg;

   // register indexes
   localparam logic CSR_FILTER_MODE = 1'b0;
   localparam logic CSR_SAMPLE_RATE = 1'b1;

   // filter modes
   localparam logic [2:0] MODE_LOWPASS  = 3'd0;
   localparam logic [2:0] MODE_BANDPASS = 3'd1;
   localparam logic [2:0] MODE_HIGHPASS = 3'd2;
   localparam logic [2:0] MODE_NOTCH    = 3'd3;
   localparam logic [2:0] MODE_PEAK     = 3'd4;

   localparam logic [2:0]  MODE_RESET = MODE_LOWPASS;
   localparam logic [17:0] FS_RESET   = 18'd48000;

   // shared divider sizes
   localparam int DIV_NUM_W = 56;
   localparam int DIV_DEN_W = 42;

   localparam longint unsigned PI_Q30  = 64'd3373259426;
   localparam longint          ONE_Q30 = 64'sd1 <<< 30;

   typedef enum logic [4:0] {
      ST_IDLE, ST_PDIV, ST_INTERP, ST_GAIN, ST_MDEN, ST_DEN, ST_A1DIV,
      ST_MA2, ST_A2, ST_MA3, ST_A3, ST_M1, ST_M2, ST_M3, ST_M4, ST_V2,
      ST_MK, ST_FIN
   } svf_state_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } svf_div_req_type;

   typedef struct packed {
      logic        done;
      logic [DIV_NUM_W-1:0] quot;
   } svf_div_rsp_type;

   typedef struct packed {
      logic [2:0]  channel;
      logic [16:0] cutoff_hz;
      logic [15:0] resonance;
      logic        ch_ok;
   } svf_item_type;

endpackage

/* src/svf_if.sv */
interface svf_req_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic [2:0]                    channel;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic [16:0]                   cutoff_hz;
   logic [15:0]                   resonance;
   modport source (output valid, channel, sample, cutoff_hz, resonance, input ready);
   modport sink   (input valid, channel, sample, cutoff_hz, resonance, output ready);
endinterface

interface svf_rsp_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic [2:0]                    out_channel;
   logic signed [SAMPLE_BITS-1:0] filtered;
   logic                          mode_error;
   modport source (output valid, out_channel, filtered, mode_error, input ready);
   modport sink   (input valid, out_channel, filtered, mode_error, output ready);
endinterface

/* src/svf_ram.sv */
module svf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8
) (
   input  logic             clock,
   input  logic             we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0] rdata_ff
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end
endmodule

/* src/svf_div.sv */
module svf_div
   import svf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  svf_div_req_type req,
   output svf_div_rsp_type rsp
);
   localparam int CNT_W = $clog2(DIV_NUM_W + 1);

   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_NUM_W-1:0] quot_ff, quot_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   trial;
   logic                 fits;

   // restoring division, one quotient bit a cycle
   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      num_in  = num_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, num_ff[DIV_NUM_W-1]};
      fits    = trial >= {1'b0, den_ff};
      if (req.start) begin
         rem_in  = '0;
         den_in  = req.den;
         num_in  = req.num;
         quot_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? DIV_DEN_W'(trial - {1'b0, den_ff}) : trial[DIV_DEN_W-1:0];
         num_in  = {num_ff[DIV_NUM_W-2:0], 1'b0};
         quot_in = {quot_ff[DIV_NUM_W-2:0], fits};
         cnt_in  = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      num_ff  <= num_in;
      quot_ff <= quot_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;
endmodule

/* src/svf_front.sv */
module svf_front
   import svf_pkg::*;
#(
   parameter int SAMPLE_BITS = 24,
   parameter int CHANNELS    = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   svf_req_if.sink                       req_if,
   output logic                          q_valid,
   input  logic                          q_ready,
   output svf_item_type                  q_item,
   output logic signed [SAMPLE_BITS-1:0] q_sample
);
   svf_item_type                  item_ff   [2];
   logic signed [SAMPLE_BITS-1:0] sample_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;
   svf_item_type incoming;

   assign req_if.ready = count_ff != 2'd2;
   assign push = req_if.valid && req_if.ready;
   assign pop  = q_valid && q_ready;

   // classify: channels outside the state store leave it untouched
   always_comb begin
      incoming.channel   = req_if.channel;
      incoming.cutoff_hz = req_if.cutoff_hz;
      incoming.resonance = req_if.resonance;
      incoming.ch_ok     = 32'(req_if.channel) < CHANNELS;
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         item_ff[wr_ptr_ff]   <= incoming;
         sample_ff[wr_ptr_ff] <= req_if.sample;
      end
   end

   assign q_valid  = count_ff != 2'd0;
   assign q_item   = item_ff[rd_ptr_ff];
   assign q_sample = sample_ff[rd_ptr_ff];
endmodule

/* src/svf_back.sv */
module svf_back
   import svf_pkg::*;
#(
   parameter int SAMPLE_BITS       = 24,
   parameter int CHANNELS          = 8,
   parameter int TAN_TABLE_ENTRIES = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [2:0]                    mode,
   input  logic [17:0]                   fs,
   input  logic                          q_valid,
   output logic                          q_ready,
   input  svf_item_type                  q_item,
   input  logic signed [SAMPLE_BITS-1:0] q_sample,
   svf_rsp_if.source                     rsp_if
);
   localparam int N      = TAN_TABLE_ENTRIES;
   localparam int IDX_W  = $clog2(N);
   localparam int ADDR_W = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
   localparam int MW     = 36;
   localparam int PW     = 2 * MW;
   localparam int RW     = 40;
   localparam longint unsigned PMAX = (64'd2 * N * 64'd65536 * 64'd12) / 64'd25;
   localparam longint unsigned PSCALE = 64'd2 * N * 64'd65536;
   localparam longint SMAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
   localparam longint SMIN = -SMAX - 64'sd1;
   localparam longint IMAX = 64'sd2147483647;
   localparam longint IMIN = -IMAX - 64'sd1;

   // tangent table, constant: Taylor series for sine and cosine in Q30, Q8.24 out
   logic [31:0] tan_rom [N];
   for (genvar gi = 0; gi < N; gi++) begin : g_rom
      localparam longint TH  = longint'((PI_Q30 * gi) / (64'd2 * N));
      localparam longint T2  = (TH * TH) >>> 30;
      localparam longint S1  = -((TH * T2) >>> 30) / 64'sd6;
      localparam longint S2  = -((S1 * T2) >>> 30) / 64'sd20;
      localparam longint S3  = -((S2 * T2) >>> 30) / 64'sd42;
      localparam longint S4  = -((S3 * T2) >>> 30) / 64'sd72;
      localparam longint S5  = -((S4 * T2) >>> 30) / 64'sd110;
      localparam longint S6  = -((S5 * T2) >>> 30) / 64'sd156;
      localparam longint S7  = -((S6 * T2) >>> 30) / 64'sd210;
      localparam longint S8  = -((S7 * T2) >>> 30) / 64'sd272;
      localparam longint S9  = -((S8 * T2) >>> 30) / 64'sd342;
      localparam longint S10 = -((S9 * T2) >>> 30) / 64'sd420;
      localparam longint S11 = -((S10 * T2) >>> 30) / 64'sd506;
      localparam longint S12 = -((S11 * T2) >>> 30) / 64'sd600;
      localparam longint SN  = TH + S1 + S2 + S3 + S4 + S5 + S6 + S7 + S8 + S9 + S10
                               + S11 + S12;
      localparam longint C1  = -((ONE_Q30 * T2) >>> 30) / 64'sd2;
      localparam longint C2  = -((C1 * T2) >>> 30) / 64'sd12;
      localparam longint C3  = -((C2 * T2) >>> 30) / 64'sd30;
      localparam longint C4  = -((C3 * T2) >>> 30) / 64'sd56;
      localparam longint C5  = -((C4 * T2) >>> 30) / 64'sd90;
      localparam longint C6  = -((C5 * T2) >>> 30) / 64'sd132;
      localparam longint C7  = -((C6 * T2) >>> 30) / 64'sd182;
      localparam longint C8  = -((C7 * T2) >>> 30) / 64'sd240;
      localparam longint C9  = -((C8 * T2) >>> 30) / 64'sd306;
      localparam longint C10 = -((C9 * T2) >>> 30) / 64'sd380;
      localparam longint C11 = -((C10 * T2) >>> 30) / 64'sd462;
      localparam longint C12 = -((C11 * T2) >>> 30) / 64'sd552;
      localparam longint CS  = ONE_Q30 + C1 + C2 + C3 + C4 + C5 + C6 + C7 + C8 + C9
                               + C10 + C11 + C12;
      localparam longint SNC = (SN < 0) ? 64'sd0 : SN;
      localparam longint unsigned G = (CS <= 0) ? 64'hFFFF_FFFF :
                                      ($unsigned(SNC) << 24) / $unsigned(CS);
      localparam logic [31:0] TV = (G > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(G);
      assign tan_rom[gi] = TV;
   end

   svf_state_type state_ff, state_in;

   logic [2:0]                    ch_ff, ch_in;
   logic                          ok_ff, ok_in;
   logic signed [SAMPLE_BITS-1:0] v0_ff, v0_in;
   logic [15:0]                   r_ff, r_in;
   logic [IDX_W-1:0]              i0_ff, i0_in;
   logic [15:0]                   fr_ff, fr_in;
   logic [31:0]                   t0_ff, t0_in;
   logic [31:0]                   g_ff, g_in;
   logic [33:0]                   gk_ff, gk_in;
   logic signed [MW-1:0]          a1_ff, a1_in, a2_ff, a2_in, a3_ff, a3_in;
   logic signed [31:0]            ic1_ff, ic1_in, ic2_ff, ic2_in;
   logic signed [MW-1:0]          v3_ff, v3_in, v1_ff, v1_in, v2_ff, v2_in;
   logic signed [PW-1:0]          acc_ff, acc_in, prod_ff;
   logic signed [MW-1:0]          mul_a, mul_b;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [2:0]                    rsp_ch_ff, rsp_ch_in;
   logic signed [SAMPLE_BITS-1:0] rsp_filt_ff, rsp_filt_in;
   logic                          rsp_err_ff, rsp_err_in;

   logic [CHANNELS-1:0]           valid_ff, valid_in;
   logic [63:0]                   ram_rdata;
   logic                          ram_we, ram_re;
   logic [63:0]                   ram_wdata;

   svf_div_req_type div_req;
   svf_div_rsp_type div_rsp;

   // scratch
   logic [41:0]          p;
   logic [25:0]          i0_full;
   logic [IDX_W-1:0]     i1;
   logic [31:0]          t1, diff;
   logic [16:0]          kbase;
   logic [41:0]          denom;
   logic signed [PW:0]   rsum;
   logic signed [RW-1:0] kv1, hp, v1w, v2w, v0w, res, st1, st2;
   logic                 err;

   svf_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   svf_ram #(.WIDTH(64), .DEPTH(CHANNELS)) u_state (
      .clock    (clock),
      .we       (ram_we),
      .waddr    (ADDR_W'(ch_ff)),
      .wdata    (ram_wdata),
      .re       (ram_re),
      .raddr    (ADDR_W'(ch_ff)),
      .rdata_ff (ram_rdata)
   );

   // shared multiplier, product registered
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      ok_in        = ok_ff;
      v0_in        = v0_ff;
      r_in         = r_ff;
      i0_in        = i0_ff;
      fr_in        = fr_ff;
      t0_in        = t0_ff;
      g_in         = g_ff;
      gk_in        = gk_ff;
      a1_in        = a1_ff;
      a2_in        = a2_ff;
      a3_in        = a3_ff;
      ic1_in       = ic1_ff;
      ic2_in       = ic2_ff;
      v3_in        = v3_ff;
      v1_in        = v1_ff;
      v2_in        = v2_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_ch_in    = rsp_ch_ff;
      rsp_filt_in  = rsp_filt_ff;
      rsp_err_in   = rsp_err_ff;
      valid_in     = valid_ff;
      q_ready      = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      div_req      = '0;

      p       = (64'(div_rsp.quot) > PMAX) ? 42'(PMAX) : div_rsp.quot[41:0];
      i0_full = p[41:16];
      i1      = (i0_ff == IDX_W'(N - 1)) ? i0_ff : i0_ff + IDX_W'(1);
      t1      = tan_rom[i1];
      diff    = (t1 >= tan_rom[i0_ff]) ? t1 - tan_rom[i0_ff] : 32'd0;
      kbase   = 17'd65536 - {1'b0, r_ff};
      denom   = 42'd16777216 + prod_ff[65:24];
      rsum    = (PW + 1)'(acc_ff) + (PW + 1)'(prod_ff) + (PW + 1)'(64'sd536870912);
      kv1     = RW'($signed(prod_ff + PW'(64'sd32768)) >>> 16);
      v0w     = RW'(v0_ff);
      v1w     = RW'(v1_ff);
      v2w     = RW'(v2_ff);
      hp      = v0w - kv1 - v2w;
      st1     = (v1w <<< 1) - RW'(ic1_ff);
      st2     = (v2w <<< 1) - RW'(ic2_ff);
      err     = 1'b0;
      unique case (mode)
         MODE_LOWPASS:  res = v2w;
         MODE_BANDPASS: res = v1w;
         MODE_HIGHPASS: res = hp;
         MODE_NOTCH:    res = v2w + hp;
         MODE_PEAK:     res = v2w - hp;
         default: begin
            res = '0;
            err = 1'b1;
         end
      endcase
      ram_wdata = {
         (st2 > RW'(IMAX)) ? 32'(IMAX) : (st2 < RW'(IMIN)) ? 32'(IMIN) : st2[31:0],
         (st1 > RW'(IMAX)) ? 32'(IMAX) : (st1 < RW'(IMIN)) ? 32'(IMIN) : st1[31:0]
      };

      unique case (state_ff)
         ST_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               ch_in         = q_item.channel;
               ok_in         = q_item.ch_ok;
               v0_in         = q_sample;
               r_in          = q_item.resonance;
               div_req.start = 1'b1;
               div_req.num   = DIV_NUM_W'(q_item.cutoff_hz) * DIV_NUM_W'(PSCALE);
               div_req.den   = (fs == 18'd0) ? DIV_DEN_W'(1) : DIV_DEN_W'(fs);
               state_in      = ST_PDIV;
            end
         end
         ST_PDIV: begin
            if (div_rsp.done) begin
               i0_in    = (i0_full > 26'(N - 1)) ? IDX_W'(N - 1) : i0_full[IDX_W-1:0];
               fr_in    = p[15:0];
               state_in = ST_INTERP;
            end
         end
         ST_INTERP: begin
            t0_in    = tan_rom[i0_ff];
            mul_a    = MW'(diff);
            mul_b    = MW'(fr_ff);
            ram_re   = 1'b1;
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            g_in     = t0_ff + prod_ff[47:16];
            gk_in    = 34'(g_in) + 34'({kbase, 9'd0});
            state_in = ST_MDEN;
         end
         ST_MDEN: begin
            mul_a    = MW'(g_ff);
            mul_b    = MW'(gk_ff);
            state_in = ST_DEN;
         end
         ST_DEN: begin
            div_req.start = 1'b1;
            div_req.num   = (DIV_NUM_W'(1) << 54) + DIV_NUM_W'(denom >> 1);
            div_req.den   = denom;
            state_in      = ST_A1DIV;
         end
         ST_A1DIV: begin
            if (div_rsp.done) begin
               a1_in    = $signed(div_rsp.quot[MW-1:0]);
               state_in = ST_MA2;
            end
         end
         ST_MA2: begin
            mul_a    = MW'(g_ff);
            mul_b    = a1_ff;
            state_in = ST_A2;
         end
         ST_A2: begin
            a2_in    = $signed(prod_ff[MW+23:24]);
            ic1_in   = valid_ff[ADDR_W'(ch_ff)] ? $signed(ram_rdata[31:0]) : 32'sd0;
            ic2_in   = valid_ff[ADDR_W'(ch_ff)] ? $signed(ram_rdata[63:32]) : 32'sd0;
            v3_in    = MW'(v0_ff) - MW'(ic2_in);
            state_in = ST_MA3;
         end
         ST_MA3: begin
            mul_a    = MW'(g_ff);
            mul_b    = a2_ff;
            state_in = ST_A3;
         end
         ST_A3: begin
            a3_in    = $signed(prod_ff[MW+23:24]);
            state_in = ST_M1;
         end
         ST_M1: begin
            mul_a    = a1_ff;
            mul_b    = MW'(ic1_ff);
            state_in = ST_M2;
         end
         ST_M2: begin
            acc_in   = prod_ff;
            mul_a    = a2_ff;
            mul_b    = v3_ff;
            state_in = ST_M3;
         end
         ST_M3: begin
            v1_in    = MW'(rsum >>> 30);
            mul_a    = a2_ff;
            mul_b    = MW'(ic1_ff);
            state_in = ST_M4;
         end
         ST_M4: begin
            acc_in   = prod_ff;
            mul_a    = a3_ff;
            mul_b    = v3_ff;
            state_in = ST_V2;
         end
         ST_V2: begin
            v2_in    = MW'(ic2_ff) + MW'(rsum >>> 30);
            state_in = ST_MK;
         end
         ST_MK: begin
            mul_a    = MW'({kbase, 1'b0});
            mul_b    = v1_ff;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // keep k*v1 on the multiplier while the output register is full
            mul_a = MW'({kbase, 1'b0});
            mul_b = v1_ff;
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_ch_in    = ch_ff;
               if (ok_ff) begin
                  rsp_err_in  = err;
                  rsp_filt_in = (res > RW'(SMAX)) ? SAMPLE_BITS'(SMAX) :
                                (res < RW'(SMIN)) ? SAMPLE_BITS'(SMIN) :
                                res[SAMPLE_BITS-1:0];
                  ram_we      = 1'b1;
                  valid_in[ADDR_W'(ch_ff)] = 1'b1;
               end else begin
                  rsp_err_in  = 1'b0;
                  rsp_filt_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
      end
      ch_ff       <= ch_in;
      ok_ff       <= ok_in;
      v0_ff       <= v0_in;
      r_ff        <= r_in;
      i0_ff       <= i0_in;
      fr_ff       <= fr_in;
      t0_ff       <= t0_in;
      g_ff        <= g_in;
      gk_ff       <= gk_in;
      a1_ff       <= a1_in;
      a2_ff       <= a2_in;
      a3_ff       <= a3_in;
      ic1_ff      <= ic1_in;
      ic2_ff      <= ic2_in;
      v3_ff       <= v3_in;
      v1_ff       <= v1_in;
      v2_ff       <= v2_in;
      acc_ff      <= acc_in;
      rsp_ch_ff   <= rsp_ch_in;
      rsp_filt_ff <= rsp_filt_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.out_channel = rsp_ch_ff;
   assign rsp_if.filtered    = rsp_filt_ff;
   assign rsp_if.mode_error  = rsp_err_ff;
endmodule

/* src/state_variable_filter_core.sv */
// Trapezoidal state variable filter with per-channel integrator state.
// Each item on req_if carries a channel, a signed Q1.x sample, a cutoff in Hz
// and a Q0.16 resonance; one item comes back on rsp_if with the selected
// response (low-pass, band-pass, high-pass, notch or peak), saturated.
// An unsupported mode still updates the integrators but returns zero with
// mode_error set; a channel at or above CHANNELS returns zero and leaves state
// alone. Each item takes two passes through the shared restoring divider
// (one quotient bit a cycle) for the cutoff position and for a1, plus
// sequenced multiplies on the one shared 36x36 multiplier. A two-item queue
// sits in front, so up to two items are taken while the sequencer is busy,
// and the output register lets the next item start while a result waits.
// Configuration (filter_mode at index 0, sample_rate_hz at index 1) is to be
// written by the user only while the block is idle; nothing enforces that.
module state_variable_filter_core
   import svf_pkg::*;
#(
   parameter int CHANNELS          = 8,
   parameter int TAN_TABLE_ENTRIES = 256,
   parameter int SAMPLE_BITS       = 24
) (
   input  logic        clock,
   input  logic        reset,
   svf_req_if.sink     req_if,
   svf_rsp_if.source   rsp_if,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [17:0] csr_wdata
);
   logic [2:0]  mode_ff, mode_in;
   logic [17:0] fs_ff, fs_in;

   logic                          q_valid, q_ready;
   svf_item_type                  q_item;
   logic signed [SAMPLE_BITS-1:0] q_sample;

   // config registers
   always_comb begin
      mode_in = mode_ff;
      fs_in   = fs_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FILTER_MODE: mode_in = csr_wdata[2:0];
            CSR_SAMPLE_RATE: fs_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
         fs_ff   <= FS_RESET;
      end else begin
         mode_ff <= mode_in;
         fs_ff   <= fs_in;
      end
   end

   // front: accept and classify, queue
   svf_front #(.SAMPLE_BITS(SAMPLE_BITS), .CHANNELS(CHANNELS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_item   (q_item),
      .q_sample (q_sample)
   );

   // back: coefficients, integrator update, response
   svf_back #(
      .SAMPLE_BITS       (SAMPLE_BITS),
      .CHANNELS          (CHANNELS),
      .TAN_TABLE_ENTRIES (TAN_TABLE_ENTRIES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .mode     (mode_ff),
      .fs       (fs_ff),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_item   (q_item),
      .q_sample (q_sample),
      .rsp_if   (rsp_if)
   );

   a_mode_write: assert property (@(posedge clock) disable iff (reset)
      csr_we && csr_index == CSR_FILTER_MODE |=> mode_ff == $past(csr_wdata[2:0]))
      else $error("filter mode write lost");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.mode_error |-> rsp_if.filtered == '0)
      else $error("mode error with non-zero output");

   a_err_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.mode_error |->
         mode_ff != MODE_LOWPASS && mode_ff != MODE_BANDPASS &&
         mode_ff != MODE_HIGHPASS && mode_ff != MODE_NOTCH && mode_ff != MODE_PEAK)
      else $error("mode error flagged for a supported mode");
endmodule

/* tb/sv/tb_svf_ifs.sv */
`timescale 1ns / 1ps
// Channel interfaces come from the RTL (svf_req_if / svf_rsp_if); this file
// only holds the item types that the bench keeps in its queues.
package tb_svf_types;

   typedef struct {
      logic [2:0]         channel;
      logic signed [23:0] filtered;
      logic               mode_error;
   } svf_result_type;

endpackage

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
   import svf_pkg::*;
   import tb_svf_types::*;

   localparam int  NCH      = 8;
   localparam int  TAB_N    = 256;
   localparam int  N_RANDOM = 930;
   localparam longint LIMIT = 1500000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_we    = 1'b0;
   logic        csr_index = CSR_FILTER_MODE;
   logic [17:0] csr_wdata = '0;

   svf_req_if #(.SAMPLE_BITS(24)) req_if ();
   svf_rsp_if #(.SAMPLE_BITS(24)) rsp_if ();

   state_variable_filter_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if.sink),
      .rsp_if    (rsp_if.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor copy of the block's state and registers
   logic [31:0]  tan_lut [TAB_N];
   longint       integ1 [NCH];
   longint       integ2 [NCH];
   logic [2:0]   cur_mode;
   logic [17:0]  cur_fs;

   svf_result_type expected_q[$];
   int           errors     = 0;
   int           n_results  = 0;
   int           n_items    = 0;
   int           send_idle  = 0;   // percent
   int           recv_idle  = 0;
   bit           recv_hold  = 1'b0;
   longint       cycles     = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // -------- arithmetic helpers, floor semantics as the block uses --------
   function automatic longint fshift(longint x, int s);
      return x >>> s;   // arithmetic shift is floor for signed values
   endfunction

   function automatic longint rshift(longint x, int s);
      return (x + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint sat(longint v, int bits);
      longint hi;
      longint lo;
      hi = (64'sd1 <<< (bits - 1)) - 1;
      lo = -hi - 1;
      return (v > hi) ? hi : ((v < lo) ? lo : v);
   endfunction

   // build the tan table in Q8.24 by integer Taylor series
   task automatic build_tan_lut();
      longint th, t2, sn, cs, term;
      longint unsigned g;
      for (int i = 0; i < TAB_N; i++) begin
         th = longint'((64'd3373259426 * longint'(i)) / (2 * TAB_N));
         t2 = fshift(th * th, 30);
         sn = th;
         term = th;
         for (int n = 1; n <= 12; n++) begin
            term = -fshift(term * t2, 30) / longint'((2 * n) * (2 * n + 1));
            sn += term;
         end
         cs = 64'sd1 <<< 30;
         term = cs;
         for (int n = 1; n <= 12; n++) begin
            term = -fshift(term * t2, 30) / longint'((2 * n - 1) * (2 * n));
            cs += term;
         end
         if (sn < 0) sn = 0;
         if (cs <= 0) g = 64'hFFFF_FFFF;
         else g = (unsigned'(sn) << 24) / unsigned'(cs);
         tan_lut[i] = (g > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : g[31:0];
      end
   endtask

   // filter one item, updating the predictor's integrators
   function automatic svf_result_type filter_item(logic [2:0] ch, logic signed [23:0] smp,
                                                  logic [16:0] fc, logic [15:0] res);
      svf_result_type r;
      longint unsigned fs, pmax, p, i0, i1, fr, t0, t1, g, k24, den;
      longint a1, a2, a3, k16, v0, ic1, ic2, v1, v2, v3, kv1, hp, y;
      r.channel = ch;
      r.filtered = '0;
      r.mode_error = 1'b0;
      if (ch >= NCH) return r;
      v0  = smp;
      fs  = (cur_fs != 0) ? 64'(cur_fs) : 64'd1;
      pmax = (64'd2 * TAB_N * 65536 * 12) / 25;
      p   = (64'(fc) * 2 * TAB_N * 65536) / fs;
      if (p > pmax) p = pmax;
      i0  = p >> 16;
      fr  = p & 16'hFFFF;
      if (i0 > TAB_N - 1) i0 = TAB_N - 1;
      i1  = (i0 + 1 > TAB_N - 1) ? TAB_N - 1 : i0 + 1;
      t0  = tan_lut[i0];
      t1  = tan_lut[i1];
      g   = (t1 >= t0) ? t0 + (((t1 - t0) * fr) >> 16) : t0;
      k16 = 2 * (65536 - longint'(res));
      k24 = 64'(65536 - res) << 9;
      den = (64'd1 << 24) + ((g * (g + k24)) >> 24);
      a1  = longint'(((64'd1 << 54) + den / 2) / den);
      a2  = longint'((g * unsigned'(a1)) >> 24);
      a3  = longint'((g * unsigned'(a2)) >> 24);
      ic1 = integ1[ch];
      ic2 = integ2[ch];
      v3  = v0 - ic2;
      v1  = rshift(a1 * ic1 + a2 * v3, 30);
      v2  = ic2 + rshift(a2 * ic1 + a3 * v3, 30);
      integ1[ch] = sat(2 * v1 - ic1, 32);
      integ2[ch] = sat(2 * v2 - ic2, 32);
      kv1 = rshift(k16 * v1, 16);
      hp  = v0 - kv1 - v2;
      case (cur_mode)
         MODE_LOWPASS:  y = v2;
         MODE_BANDPASS: y = v1;
         MODE_HIGHPASS: y = hp;
         MODE_NOTCH:    y = v2 + hp;
         MODE_PEAK:     y = v2 - hp;
         default: begin
            y = 0;
            r.mode_error = 1'b1;
         end
      endcase
      r.filtered = sat(y, 24);
      return r;
   endfunction

   // -------- stimulus --------
   typedef struct {
      logic [2:0]  ch;
      logic [23:0] smp;
      logic [16:0] fc;
      logic [15:0] res;
      bit          known;      // typed-in expectation present
      logic [23:0] exp_filt;
      logic        exp_err;
   } stim_row_type;

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [17:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_FILTER_MODE) cur_mode = val[2:0];
      else cur_fs = val;
   endtask

   // offer one item, holding it until accepted; prediction is made at acceptance
   task automatic send_item(logic [2:0] ch, logic [23:0] smp, logic [16:0] fc,
                            logic [15:0] res);
      svf_result_type e;
      while ($urandom_range(99) < send_idle) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.channel   <= ch;
      req_if.sample    <= smp;
      req_if.cutoff_hz <= fc;
      req_if.resonance <= res;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      e = filter_item(ch, smp, fc, res);
      expected_q.push_back(e);
      n_items++;
   endtask

   function automatic logic [16:0] rand_cutoff();
      case ($urandom_range(3))
         0: return 17'($urandom_range(200));
         1: return 17'($urandom_range(96000));
         2: return 17'($urandom_range(131071));
         default: return 17'($urandom_range(20000, 100));
      endcase
   endfunction

   function automatic logic [23:0] rand_sample();
      case ($urandom_range(4))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         default: return 24'($urandom());
      endcase
   endfunction

   stim_row_type dir_tab[$];

   initial begin
      stim_row_type row;
      logic [2:0] modes[5];
      req_if.valid     <= 1'b0;
      req_if.channel   <= '0;
      req_if.sample    <= '0;
      req_if.cutoff_hz <= '0;
      req_if.resonance <= '0;
      cur_mode = MODE_RESET;
      cur_fs   = FS_RESET;
      build_tan_lut();
      for (int c = 0; c < NCH; c++) begin
         integ1[c] = 0;
         integ2[c] = 0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows; the first checks zero in, zero out straight after reset
      dir_tab.push_back('{3'd0, 24'h000000, 17'd1000, 16'd0, 1, 24'h0, 1'b0});
      dir_tab.push_back('{3'd1, 24'h7FFFFF, 17'd0, 16'd0, 0, 24'h0, 1'b0});
      dir_tab.push_back('{3'd2, 24'h800000, 17'd96000, 16'hFFFF, 0, 24'h0, 1'b0});
      dir_tab.push_back('{3'd3, 24'h7FFFFF, 17'h1FFFF, 16'h8000, 0, 24'h0, 1'b0});
      dir_tab.push_back('{3'd7, 24'h800000, 17'd23040, 16'hFFFF, 0, 24'h0, 1'b0});
      dir_tab.push_back('{3'd7, 24'h7FFFFF, 17'd23040, 16'hFFFF, 0, 24'h0, 1'b0});
      dir_tab.push_back('{3'd4, 24'h000001, 17'd1, 16'd1, 0, 24'h0, 1'b0});
      foreach (dir_tab[i]) begin
         send_item(dir_tab[i].ch, dir_tab[i].smp, dir_tab[i].fc, dir_tab[i].res);
         if (dir_tab[i].known) begin
            expected_q[$].filtered   = dir_tab[i].exp_filt;
            expected_q[$].mode_error = dir_tab[i].exp_err;
         end
      end
      wait_drained();

      // every other mode, and unsupported codes 7 and 5: error flag and zero out
      modes = '{MODE_BANDPASS, MODE_HIGHPASS, MODE_NOTCH, MODE_PEAK, 3'd7};
      foreach (modes[m]) begin
         wait_drained();
         write_csr(CSR_FILTER_MODE, 18'(modes[m]));
         send_item(3'd5, 24'h7FFFFF, 17'd5000, 16'hF000);
         send_item(3'd5, 24'h800000, 17'd5000, 16'hF000);
      end
      wait_drained();
      write_csr(CSR_FILTER_MODE, 18'd5);
      send_item(3'd6, 24'h123456, 17'd100, 16'd0);
      wait_drained();

      // zero sample rate and the extremes of the rate register
      write_csr(CSR_FILTER_MODE, 18'(MODE_LOWPASS));
      write_csr(CSR_SAMPLE_RATE, 18'd0);
      send_item(3'd0, 24'h400000, 17'd10, 16'd100);
      wait_drained();
      write_csr(CSR_SAMPLE_RATE, 18'h3FFFF);
      send_item(3'd0, 24'h400000, 17'd96000, 16'd100);
      wait_drained();

      // random phases, each rewriting the registers and setting an idling pattern
      for (int ph = 0; ph < 6; ph++) begin
         wait_drained();
         write_csr(CSR_FILTER_MODE, 18'($urandom_range(7)));
         case (ph)
            0: write_csr(CSR_SAMPLE_RATE, 18'd8000);
            1: write_csr(CSR_SAMPLE_RATE, 18'd192000);
            2: write_csr(CSR_SAMPLE_RATE, 18'd48000);
            default: write_csr(CSR_SAMPLE_RATE, 18'($urandom_range(192000, 8000)));
         endcase
         if (ph < 2) begin
            send_idle = 14;
            recv_idle = 77;
         end else if (ph < 4) begin
            send_idle = 77;
            recv_idle = 14;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         if (ph == 4) recv_hold = 1'b1;   // long receiver stall, inputs back up
         for (int i = 0; i < N_RANDOM / 6; i++) begin
            send_item(3'($urandom_range(7)), rand_sample(), rand_cutoff(),
                      16'($urandom()));
            if (i == 40 && ph == 5) wait_drained();   // sender pauses till empty
         end
      end

      wait_drained();
      $display("Covered %0d items, %0d results checked, all modes and rate extremes.",
               n_items, n_results);
      if (errors == 0) $display("tb_top passed");
      else $display("tb_top failed");
      $finish;
   end

   // receiver hold-off, counted in its own process
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (recv_hold) begin
            rsp_if.ready <= 1'b0;
            repeat (2000) @(posedge clock);
            recv_hold = 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   // result checking against the oldest expected item
   always @(posedge clock) begin
      svf_result_type e;
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_q.size() == 0) begin
            $error("unexpected result item, channel %0d", rsp_if.out_channel);
            errors++;
         end else begin
            e = expected_q.pop_front();
            n_results++;
            if (rsp_if.out_channel !== e.channel) begin
               $error("out_channel: expected %0d, got %0d", e.channel, rsp_if.out_channel);
               errors++;
            end
            if (rsp_if.filtered !== e.filtered) begin
               $error("filtered: expected %0d, got %0d", e.filtered, rsp_if.filtered);
               errors++;
            end
            if (rsp_if.mode_error !== e.mode_error) begin
               $error("mode_error: expected %0d, got %0d", e.mode_error, rsp_if.mode_error);
               errors++;
            end
         end
      end
   end

endmodule
